// ----- rtl/rsbq_pkg.sv -----
// Shared types and constants of the bucketed range-sum store.
package rsbq_pkg;

	localparam int DATA_W = 64;
	localparam int IDX_W  = 10;
	localparam int STAT_W = 2;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic                     start_new;
		logic signed [DATA_W-1:0] value;
		logic        [IDX_W-1:0]  left;
		logic        [IDX_W-1:0]  right;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sum;
		logic        [STAT_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_RD,
		S_LOAD_WR,
		S_QCHK,
		S_QBKT,
		S_WALK,
		S_DRAIN,
		S_RESULT
	} seq_state_t;

	// accumulator control, aligned with returning read data
	typedef struct packed {
		logic clr;
		logic add_bkt;
		logic add_elem;
		logic sub;
	} acc_ctrl_t;

	typedef struct packed {
		logic              load;
		logic [STAT_W-1:0] status;
	} res_ctrl_t;

endpackage

// ----- rtl/rsbq_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface rsbq_req_if;
	logic          valid;
	logic          ready;
	rsbq_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rsbq_rsp_if;
	logic          valid;
	logic          ready;
	rsbq_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/rsbq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module rsbq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/rsbq_seq.sv -----
// Sequencer: item capture, count, bucket valid bits, load update and query walk.
module rsbq_seq #(
	parameter int MAX_ENTRIES = 1024,
	parameter int BUCKET_SIZE = 32,
	parameter int NUM_BUCKETS = 32,
	localparam int IW = $clog2(MAX_ENTRIES),
	localparam int BIW = $clog2(NUM_BUCKETS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rsbq_req_if.sink                    req,
	input  logic                        res_busy,
	output rsbq_pkg::acc_ctrl_t         acc_ctrl,
	output rsbq_pkg::res_ctrl_t         res_ctrl,
	output logic                        el_we,
	output logic [IW-1:0]               el_waddr,
	output logic [rsbq_pkg::DATA_W-1:0] el_wdata,
	output logic                        el_re,
	output logic [IW-1:0]               el_raddr,
	output logic                        bk_we,
	output logic [BIW-1:0]              bk_waddr,
	output logic [rsbq_pkg::DATA_W-1:0] bk_wdata,
	output logic                        bk_re,
	output logic [BIW-1:0]              bk_raddr,
	input  logic [rsbq_pkg::DATA_W-1:0] bk_rdata
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int BW = $clog2(BUCKET_SIZE);
	localparam int VW = (CW > rsbq_pkg::IDX_W) ? CW : rsbq_pkg::IDX_W;
	localparam int PW = ((IW > BW) ? IW : BW) + 1;

	rsbq_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0]               count_q;
	logic [NUM_BUCKETS-1:0]      bvalid_q;
	logic [rsbq_pkg::DATA_W-1:0] value_q;
	logic [VW-1:0]               left_q, right_q;
	logic [rsbq_pkg::STAT_W-1:0] status_q;
	logic [BIW-1:0]              b_q, last_b_q;
	logic [IW-1:0]               ptr_q, end_q, sp2_lo_q, sp2_hi_q;
	logic                        sp2_pend_q, sub_q;
	logic                        el_pend_s1, bk_pend_s1, bk_valid_s1, sub_s1;

	logic           accept, store_full, done_b, at_end;
	logic [BIW-1:0] ld_baddr;
	logic [PW-1:0]  bstart, bend_raw, bend, cnt_m1, lo_p, hi_p, a_p, z_p, len_p;
	logic           full_cov, short_span, use_bk, qb_rd;
	logic           first_v, second_v;
	logic [PW-1:0]  first_lo, first_hi, second_lo, second_hi;

	assign accept   = req.valid && req.ready;
	assign ld_baddr = BIW'(count_q >> BW);
	assign store_full = (32'(count_q) >= MAX_ENTRIES) ||
	                    ((32'(count_q) >> BW) >= NUM_BUCKETS);
	assign done_b   = (b_q == last_b_q);
	assign at_end   = (ptr_q == end_q);

	// bucket geometry for the bucket under work
	always_comb begin
		bstart     = PW'(b_q) << BW;
		bend_raw   = bstart + PW'(BUCKET_SIZE - 1);
		cnt_m1     = PW'(count_q) - PW'(1);
		bend       = (bend_raw > cnt_m1) ? cnt_m1 : bend_raw;
		lo_p       = PW'(left_q);
		hi_p       = PW'(right_q);
		a_p        = (bstart > lo_p) ? bstart : lo_p;
		z_p        = (bend < hi_p) ? bend : hi_p;
		len_p      = z_p - a_p + PW'(1);
		full_cov   = (a_p == bstart) && (z_p == bend);
		short_span = (32'(len_p) <= BUCKET_SIZE / 2);
		use_bk     = full_cov || !short_span;
		first_v    = 1'b0;
		first_lo   = a_p;
		first_hi   = z_p;
		second_v   = 1'b0;
		second_lo  = z_p + PW'(1);
		second_hi  = bend;
		if (!full_cov && short_span) begin
			first_v = 1'b1;
		end else if (!full_cov) begin
			if (a_p > bstart) begin
				first_v  = 1'b1;
				first_lo = bstart;
				first_hi = a_p - PW'(1);
				second_v = (z_p < bend);
			end else begin
				first_v  = 1'b1;
				first_lo = z_p + PW'(1);
				first_hi = bend;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsbq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		req.ready       = 1'b0;
		qb_rd           = 1'b0;
		el_re           = 1'b0;
		el_raddr        = ptr_q;
		el_we           = 1'b0;
		el_waddr        = IW'(count_q);
		el_wdata        = value_q;
		bk_re           = 1'b0;
		bk_raddr        = ld_baddr;
		bk_we           = 1'b0;
		bk_waddr        = ld_baddr;
		bk_wdata        = (bk_valid_s1 ? bk_rdata : '0) + value_q;
		res_ctrl.load   = 1'b0;
		res_ctrl.status = status_q;
		unique case (state_q)
			rsbq_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (req.data.mode == rsbq_pkg::MODE_QUERY) ?
					          rsbq_pkg::S_QCHK : rsbq_pkg::S_LOAD_RD;
				end
			end
			rsbq_pkg::S_LOAD_RD: begin
				if (store_full) begin
					state_d = rsbq_pkg::S_RESULT;
				end else begin
					bk_re   = 1'b1;
					state_d = rsbq_pkg::S_LOAD_WR;
				end
			end
			rsbq_pkg::S_LOAD_WR: begin
				el_we   = 1'b1;
				bk_we   = 1'b1;
				state_d = rsbq_pkg::S_RESULT;
			end
			rsbq_pkg::S_QCHK: begin
				if (left_q > right_q || right_q >= VW'(count_q)) begin
					state_d = rsbq_pkg::S_RESULT;
				end else begin
					state_d = rsbq_pkg::S_QBKT;
				end
			end
			rsbq_pkg::S_QBKT: begin
				qb_rd    = use_bk;
				bk_re    = use_bk;
				bk_raddr = b_q;
				if (first_v) begin
					state_d = rsbq_pkg::S_WALK;
				end else if (done_b) begin
					state_d = rsbq_pkg::S_DRAIN;
				end
			end
			rsbq_pkg::S_WALK: begin
				el_re = 1'b1;
				if (at_end && !sp2_pend_q) begin
					state_d = done_b ? rsbq_pkg::S_DRAIN : rsbq_pkg::S_QBKT;
				end
			end
			rsbq_pkg::S_DRAIN: begin
				state_d = rsbq_pkg::S_RESULT;
			end
			rsbq_pkg::S_RESULT: begin
				if (!res_busy) begin
					res_ctrl.load = 1'b1;
					state_d       = rsbq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rsbq_pkg::S_IDLE;
			end
		endcase
	end

	assign acc_ctrl.clr      = accept;
	assign acc_ctrl.add_bkt  = bk_pend_s1 && bk_valid_s1;
	assign acc_ctrl.add_elem = el_pend_s1;
	assign acc_ctrl.sub      = sub_s1;

	// control state: count, bucket valid bits, read-return flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			bvalid_q   <= '0;
			el_pend_s1 <= 1'b0;
			bk_pend_s1 <= 1'b0;
		end else begin
			if (accept && req.data.mode == rsbq_pkg::MODE_LOAD && req.data.start_new) begin
				count_q  <= '0;
				bvalid_q <= '0;
			end else if (state_q == rsbq_pkg::S_LOAD_WR) begin
				count_q            <= count_q + 1'b1;
				bvalid_q[ld_baddr] <= 1'b1;
			end
			el_pend_s1 <= el_re;
			bk_pend_s1 <= qb_rd;
		end
	end

	// item fields and walk pointers
	always_ff @(posedge clk) begin
		sub_s1 <= sub_q;
		if (bk_re) begin
			bk_valid_s1 <= bvalid_q[bk_raddr];
		end
		if (accept) begin
			value_q  <= req.data.value;
			left_q   <= VW'(req.data.left);
			right_q  <= VW'(req.data.right);
			status_q <= rsbq_pkg::STATUS_OK;
		end
		unique case (state_q)
			rsbq_pkg::S_LOAD_RD: begin
				if (store_full) begin
					status_q <= rsbq_pkg::STATUS_FULL;
				end
			end
			rsbq_pkg::S_QCHK: begin
				if (left_q > right_q || right_q >= VW'(count_q)) begin
					status_q <= rsbq_pkg::STATUS_RANGE;
				end
				b_q      <= BIW'(left_q >> BW);
				last_b_q <= BIW'(right_q >> BW);
			end
			rsbq_pkg::S_QBKT: begin
				if (first_v) begin
					ptr_q      <= IW'(first_lo);
					end_q      <= IW'(first_hi);
					sub_q      <= !short_span;
					sp2_pend_q <= second_v;
					sp2_lo_q   <= IW'(second_lo);
					sp2_hi_q   <= IW'(second_hi);
				end else if (!done_b) begin
					b_q <= b_q + 1'b1;
				end
			end
			rsbq_pkg::S_WALK: begin
				if (!at_end) begin
					ptr_q <= ptr_q + 1'b1;
				end else if (sp2_pend_q) begin
					ptr_q      <= sp2_lo_q;
					end_q      <= sp2_hi_q;
					sp2_pend_q <= 1'b0;
				end else if (!done_b) begin
					b_q <= b_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/range_sum_bucket_query.sv -----
// Top level of the bucketed range-sum store: memories, accumulator, result register.
//
//  channel | dir | beat                                   | accepted when
//  --------+-----+----------------------------------------+---------------------
//  req     | in  | mode, start_new, value, left, right    | req.valid && req.ready
//  rsp     | out | sum, status                            | rsp.valid && rsp.ready
//
// One item at a time. A load reads the bucket sum, then writes back the element
// and the bucket sum before the result; a store-full load skips both steps.
// A query touches B buckets on the bucket-sum RAM port and walks E elements,
// one per cycle on the element RAM read port (E is at most BUCKET_SIZE).
// Reset clears the count and the per-bucket valid bits; no clearing pass.
// A finished result waits in the output register while the next beat is taken;
// a new result stalls only if that register is still occupied.
module range_sum_bucket_query #(
	parameter int MAX_ENTRIES = 1024,
	parameter int BUCKET_SIZE = 32,
	parameter int NUM_BUCKETS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	rsbq_req_if.sink   req,
	rsbq_rsp_if.source rsp
);

	localparam int IW  = $clog2(MAX_ENTRIES);
	localparam int BIW = $clog2(NUM_BUCKETS);
	localparam int DW  = rsbq_pkg::DATA_W;

	rsbq_pkg::acc_ctrl_t acc_ctrl;
	rsbq_pkg::res_ctrl_t res_ctrl;

	logic           el_we, el_re, bk_we, bk_re;
	logic [IW-1:0]  el_waddr, el_raddr;
	logic [BIW-1:0] bk_waddr, bk_raddr;
	logic [DW-1:0]  el_wdata, el_rdata, bk_wdata, bk_rdata;

	logic [DW-1:0]               acc_q;
	logic                        out_valid_q;
	logic [DW-1:0]               out_sum_q;
	logic [rsbq_pkg::STAT_W-1:0] out_status_q;
	logic                        res_busy;

	assign res_busy = out_valid_q && !rsp.ready;

	rsbq_seq #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.BUCKET_SIZE(BUCKET_SIZE),
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.res_busy(res_busy),
		.acc_ctrl(acc_ctrl),
		.res_ctrl(res_ctrl),
		.el_we   (el_we),
		.el_waddr(el_waddr),
		.el_wdata(el_wdata),
		.el_re   (el_re),
		.el_raddr(el_raddr),
		.bk_we   (bk_we),
		.bk_waddr(bk_waddr),
		.bk_wdata(bk_wdata),
		.bk_re   (bk_re),
		.bk_raddr(bk_raddr),
		.bk_rdata(bk_rdata)
	);

	// element store: written on append, walked on partial buckets
	rsbq_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_elem_ram (
		.clk  (clk),
		.we   (el_we),
		.waddr(el_waddr),
		.wdata(el_wdata),
		.re   (el_re),
		.raddr(el_raddr),
		.rdata(el_rdata)
	);

	// bucket sums: read-modify-write on append, read for covered buckets and for partial buckets over half covered
	rsbq_ram #(.WIDTH(DW), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
		.clk  (clk),
		.we   (bk_we),
		.waddr(bk_waddr),
		.wdata(bk_wdata),
		.re   (bk_re),
		.raddr(bk_raddr),
		.rdata(bk_rdata)
	);

	// wrapping accumulator; clear on every accepted beat so loads and
	// rejected queries report zero
	always_ff @(posedge clk) begin
		if (acc_ctrl.clr) begin
			acc_q <= '0;
		end else if (acc_ctrl.add_bkt) begin
			acc_q <= acc_q + bk_rdata;
		end else if (acc_ctrl.add_elem) begin
			acc_q <= acc_ctrl.sub ? (acc_q - el_rdata) : (acc_q + el_rdata);
		end
	end

	// output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ctrl.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ctrl.load) begin
			out_sum_q    <= acc_q;
			out_status_q <= res_ctrl.status;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data.sum    = out_sum_q;
	assign rsp.data.status = out_status_q;

	// no read data may still be in flight when the result is captured
	a_drain_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_ctrl.load |-> !acc_ctrl.add_elem && !acc_ctrl.add_bkt)
		else $error("result captured with read data still returning");

	// never overwrite a result the sink has not taken
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_ctrl.load |-> !(out_valid_q && !rsp.ready))
		else $error("result register overwritten while occupied");

	// one item at a time: after an accepted beat the input side stays closed
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second beat accepted while an item is in work");

	// bucket and element returns never collide in the accumulator
	a_single_acc_source: assert property (@(posedge clk) disable iff (!arst_n)
		acc_ctrl.add_bkt |-> !acc_ctrl.add_elem && !acc_ctrl.clr)
		else $error("accumulator sources overlap");

endmodule
